FILE: hdl/deq_pkg.sv
// Shared types, codes and defaults of the double-ended queue.
package deq_pkg;

	localparam int DEPTH_DEF = 16;
	localparam int WORD_W    = 32;
	localparam int MODE_W    = 3;
	localparam int STAT_W    = 2;
	localparam int CNT_W_DEF = $clog2(DEPTH_DEF + 1);

	localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd0;
	localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 3'd1;
	localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd2;
	localparam logic [MODE_W-1:0] MODE_POP_BACK   = 3'd3;
	localparam logic [MODE_W-1:0] MODE_CLEAR      = 3'd4;

	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

	typedef logic signed [WORD_W-1:0] word_t;

	typedef enum logic [2:0] {
		OP_HOLD,
		OP_PUSH_FRONT,
		OP_PUSH_BACK,
		OP_POP_FRONT,
		OP_POP_BACK,
		OP_CLEAR
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
		word_t    value;
	} cell_cmd_t;

endpackage

FILE: hdl/deq_if.sv
// Valid/ready channels of the double-ended queue: operation in, result out.
interface deq_in_if;
	logic                        valid;
	logic                        ready;
	logic [deq_pkg::MODE_W-1:0]  mode;
	logic signed [deq_pkg::WORD_W-1:0] push_value;

	modport source (output valid, output mode, output push_value, input ready);
	modport sink   (input valid, input mode, input push_value, output ready);
endinterface

interface deq_out_if #(
	parameter int CNT_W = deq_pkg::CNT_W_DEF
);
	logic                              valid;
	logic                              ready;
	logic [deq_pkg::STAT_W-1:0]        status;
	logic signed [deq_pkg::WORD_W-1:0] popped_value;
	logic signed [deq_pkg::WORD_W-1:0] front_value;
	logic signed [deq_pkg::WORD_W-1:0] back_value;
	logic                              not_empty;
	logic [CNT_W-1:0]                  fill_count;

	modport source (output valid, output status, output popped_value, output front_value,
		output back_value, output not_empty, output fill_count, input ready);
	modport sink   (input valid, input status, input popped_value, input front_value,
		input back_value, input not_empty, input fill_count, output ready);
endinterface

FILE: hdl/double_ended_queue.sv
// Bounded double-ended queue of signed words built as a shifting row of cells.
//
// in_ch carries one operation per item: push front, push back, pop front,
// pop back or clear, with the word to push. out_ch returns one result per
// item: status, popped word, front and back words, not-empty flag and count.
// The front entry always sits in the first cell; pushes and pops at the
// front shift the whole row by one cell, pushes at the back fill the first
// free cell, and the back word is gathered from the cell that marks itself
// last.
// The result of an accepted item passes through a stage register and then
// the output register before it is presented on out_ch. Throughput is one
// item per cycle while out_ch does not stall.
// Reset empties the queue (count zero, all cells unoccupied); stored words
// are left as they are.
// When out_ch stalls, one result waits in the output register and one in
// the stage before it; in_ch drops ready once both are held.
module double_ended_queue #(
	parameter int DEPTH = deq_pkg::DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	deq_in_if.sink    in_ch,
	deq_out_if.source out_ch
);
	import deq_pkg::*;

	localparam int CNT_W = $clog2(DEPTH + 1);

	word_t                   cell_data [DEPTH];
	logic [DEPTH-1:0]        cell_occ;
	word_t                   back_taps [DEPTH];
	word_t                   back_word;
	cell_cmd_t               cmd;

	logic [CNT_W-1:0]        count_q;
	logic [CNT_W-1:0]        count_nxt;
	logic                    full;
	logic                    empty;
	logic                    accept;
	logic                    out_free;

	logic [STAT_W-1:0]       status_nxt;
	word_t                   popped_nxt;

	logic                    valid_s1;
	logic [STAT_W-1:0]       status_s1;
	word_t                   popped_s1;

	logic                    out_valid_q;
	logic [STAT_W-1:0]       status_q;
	word_t                   popped_q;
	word_t                   front_q;
	word_t                   back_q;
	logic                    not_empty_q;
	logic [CNT_W-1:0]        fill_q;

	assign full     = count_q == CNT_W'(DEPTH);
	assign empty    = count_q == '0;
	assign out_free = !out_valid_q || out_ch.ready;
	assign in_ch.ready = !valid_s1 || out_free;
	assign accept   = in_ch.valid && in_ch.ready;

	always_comb begin
		back_word = '0;
		for (int i = 0; i < DEPTH; i++) begin
			back_word = back_word | back_taps[i];
		end
	end

	always_comb begin
		cmd.op     = OP_HOLD;
		cmd.value  = in_ch.push_value;
		status_nxt = ST_OK;
		popped_nxt = '0;
		count_nxt  = count_q;
		unique case (in_ch.mode)
			MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
				if (full) begin
					status_nxt = ST_FULL;
				end else begin
					cmd.op    = (in_ch.mode == MODE_PUSH_FRONT) ? OP_PUSH_FRONT : OP_PUSH_BACK;
					count_nxt = count_q + CNT_W'(1);
				end
			end
			MODE_POP_FRONT, MODE_POP_BACK: begin
				if (empty) begin
					status_nxt = ST_EMPTY;
				end else begin
					cmd.op     = (in_ch.mode == MODE_POP_FRONT) ? OP_POP_FRONT : OP_POP_BACK;
					popped_nxt = (in_ch.mode == MODE_POP_FRONT) ? cell_data[0] : back_word;
					count_nxt  = count_q - CNT_W'(1);
				end
			end
			MODE_CLEAR: begin
				cmd.op    = OP_CLEAR;
				count_nxt = '0;
			end
			default: begin
			end
		endcase
		if (!accept) cmd.op = OP_HOLD;
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		word_t left_data;
		logic  left_occ;
		word_t right_data;
		logic  right_occ;

		if (i == 0) begin : g_first
			assign left_data = in_ch.push_value;
			assign left_occ  = 1'b1;
		end else begin : g_inner_l
			assign left_data = cell_data[i-1];
			assign left_occ  = cell_occ[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign right_data = '0;
			assign right_occ  = 1'b0;
		end else begin : g_inner_r
			assign right_data = cell_data[i+1];
			assign right_occ  = cell_occ[i+1];
		end

		deq_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cmd        (cmd),
			.left_data  (left_data),
			.left_occ   (left_occ),
			.right_data (right_data),
			.right_occ  (right_occ),
			.data       (cell_data[i]),
			.occ        (cell_occ[i]),
			.back_tap   (back_taps[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) count_q <= count_nxt;
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (out_free) begin
				valid_s1 <= 1'b0;
			end
			if (valid_s1 && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_s1 <= status_nxt;
			popped_s1 <= popped_nxt;
		end
		if (valid_s1 && out_free) begin
			status_q    <= status_s1;
			popped_q    <= popped_s1;
			front_q     <= empty ? '0 : cell_data[0];
			back_q      <= back_word;
			not_empty_q <= !empty;
			fill_q      <= count_q;
		end
	end

	assign out_ch.valid        = out_valid_q;
	assign out_ch.status       = status_q;
	assign out_ch.popped_value = popped_q;
	assign out_ch.front_value  = front_q;
	assign out_ch.back_value   = back_q;
	assign out_ch.not_empty    = not_empty_q;
	assign out_ch.fill_count   = fill_q;

endmodule

FILE: hdl/deq_cell.sv
// One slot of the queue row: holds a word and an occupied flag, shifts with its neighbors.
module deq_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  deq_pkg::cell_cmd_t cmd,
	input  deq_pkg::word_t     left_data,
	input  logic               left_occ,
	input  deq_pkg::word_t     right_data,
	input  logic               right_occ,
	output deq_pkg::word_t     data,
	output logic               occ,
	output deq_pkg::word_t     back_tap
);
	import deq_pkg::*;

	word_t data_q;
	logic  occ_q;
	logic  is_last;

	assign is_last  = occ_q && !right_occ;
	assign data     = data_q;
	assign occ      = occ_q;
	assign back_tap = is_last ? data_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= 1'b0;
		end else begin
			unique case (cmd.op)
				OP_PUSH_FRONT: occ_q <= left_occ;
				OP_PUSH_BACK: begin
					if (!occ_q && left_occ) occ_q <= 1'b1;
				end
				OP_POP_FRONT: occ_q <= right_occ;
				OP_POP_BACK: begin
					if (is_last) occ_q <= 1'b0;
				end
				OP_CLEAR: occ_q <= 1'b0;
				default: occ_q <= occ_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_PUSH_FRONT: data_q <= left_data;
			OP_PUSH_BACK: begin
				if (!occ_q && left_occ) data_q <= cmd.value;
			end
			OP_POP_FRONT: data_q <= right_data;
			default: data_q <= data_q;
		endcase
	end

endmodule

FILE: tb/double_ended_queue_tb.sv
// Self-checking testbench of the double-ended queue: predicted results checked item by item.
module double_ended_queue_tb;
	import deq_pkg::*;

	localparam int DEPTH = DEPTH_DEF;
	localparam int CNT_W = CNT_W_DEF;
	localparam int QUIET_LIMIT = 2000;
	localparam int LONG_HOLD = 60;
	localparam int PHASE_ITEMS = 150;

	localparam logic [MODE_W-1:0] MODE_UNUSED_LO = 3'd5;
	localparam logic [MODE_W-1:0] MODE_UNUSED_HI = 3'd7;

	localparam word_t WORD_MIN = 32'sh8000_0000;
	localparam word_t WORD_MAX = 32'sh7fff_ffff;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		word_t             popped_value;
		word_t             front_value;
		word_t             back_value;
		logic              not_empty;
		logic [CNT_W-1:0]  fill_count;
	} deq_result_t;

	class deque_tracker;
		word_t       ring [DEPTH];
		int          head;
		int          count;
		int          errors;
		deq_result_t pending_results [$];

		function new();
			head = 0;
			count = 0;
			errors = 0;
			foreach (ring[i]) ring[i] = '0;
		endfunction

		function void apply_op(logic [MODE_W-1:0] m, word_t v);
			deq_result_t r;
			r = '0;
			r.status = ST_OK;
			case (m)
				MODE_PUSH_FRONT: begin
					if (count >= DEPTH) begin
						r.status = ST_FULL;
					end else begin
						head = (head + DEPTH - 1) % DEPTH;
						ring[head] = v;
						count++;
					end
				end
				MODE_PUSH_BACK: begin
					if (count >= DEPTH) begin
						r.status = ST_FULL;
					end else begin
						ring[(head + count) % DEPTH] = v;
						count++;
					end
				end
				MODE_POP_FRONT: begin
					if (count == 0) begin
						r.status = ST_EMPTY;
					end else begin
						r.popped_value = ring[head];
						head = (head + 1) % DEPTH;
						count--;
					end
				end
				MODE_POP_BACK: begin
					if (count == 0) begin
						r.status = ST_EMPTY;
					end else begin
						r.popped_value = ring[(head + count - 1) % DEPTH];
						count--;
					end
				end
				MODE_CLEAR: begin
					count = 0;
					head = 0;
				end
				default: ;
			endcase
			if (count != 0) begin
				r.front_value = ring[head];
				r.back_value = ring[(head + count - 1) % DEPTH];
			end
			r.not_empty = (count != 0);
			r.fill_count = count[CNT_W-1:0];
			pending_results.push_back(r);
		endfunction

		function void check_result(deq_result_t got);
			deq_result_t exp;
			if (pending_results.size() == 0) begin
				$error("result with no item pending");
				errors++;
				return;
			end
			exp = pending_results.pop_front();
			if (got.status !== exp.status) begin
				$error("status expected %0d got %0d", exp.status, got.status);
				errors++;
			end
			if (got.popped_value !== exp.popped_value) begin
				$error("popped_value expected %0d got %0d", exp.popped_value, got.popped_value);
				errors++;
			end
			if (got.front_value !== exp.front_value) begin
				$error("front_value expected %0d got %0d", exp.front_value, got.front_value);
				errors++;
			end
			if (got.back_value !== exp.back_value) begin
				$error("back_value expected %0d got %0d", exp.back_value, got.back_value);
				errors++;
			end
			if (got.not_empty !== exp.not_empty) begin
				$error("not_empty expected %0d got %0d", exp.not_empty, got.not_empty);
				errors++;
			end
			if (got.fill_count !== exp.fill_count) begin
				$error("fill_count expected %0d got %0d", exp.fill_count, got.fill_count);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	deq_in_if in_ch ();
	deq_out_if #(.CNT_W(CNT_W)) out_ch ();

	double_ended_queue #(.DEPTH(DEPTH)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	deque_tracker tracker;
	int idle_pct;
	int stall_pct;
	bit hold_req;
	int hold_left;
	int quiet_cycles;

	always #5 clk = ~clk;

	// receiver: random stalls, plus a long hold-off on request
	always @(posedge clk) begin
		if (hold_req) begin
			hold_req = 1'b0;
			hold_left = LONG_HOLD;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_ch.valid && out_ch.ready)
				tracker.check_result('{out_ch.status, out_ch.popped_value, out_ch.front_value,
					out_ch.back_value, out_ch.not_empty, out_ch.fill_count});
			if (in_ch.valid && in_ch.ready)
				tracker.apply_op(in_ch.mode, in_ch.push_value);
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	function automatic word_t random_word();
		case ($urandom_range(15))
			0: random_word = WORD_MIN;
			1: random_word = WORD_MAX;
			2: random_word = '0;
			3: random_word = -1;
			default: random_word = $urandom;
		endcase
	endfunction

	task automatic send_item(input logic [MODE_W-1:0] m, input word_t v);
		while ($urandom_range(99) < idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.mode <= m;
		in_ch.push_value <= v;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
	endtask

	initial begin
		int left;
		int kind;
		int burst;
		tracker = new();
		idle_pct = 0;
		stall_pct = 0;
		hold_req = 1'b0;
		hold_left = 0;
		quiet_cycles = 0;
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.mode = MODE_PUSH_FRONT;
		in_ch.push_value = '0;
		out_ch.ready = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty pops, extremes, unused codes, fill to full, clear
		send_item(MODE_POP_FRONT, random_word());
		send_item(MODE_POP_BACK, random_word());
		send_item(MODE_PUSH_FRONT, WORD_MIN);
		send_item(MODE_PUSH_BACK, WORD_MAX);
		send_item(MODE_UNUSED_LO, random_word());
		send_item(MODE_UNUSED_HI, random_word());
		for (int i = 0; i < DEPTH - 2; i++)
			send_item((i % 2) ? MODE_PUSH_BACK : MODE_PUSH_FRONT,
				(i % 3 == 0) ? WORD_MIN : (i % 3 == 1) ? WORD_MAX : random_word());
		send_item(MODE_PUSH_FRONT, random_word());
		send_item(MODE_PUSH_BACK, random_word());
		send_item(MODE_POP_FRONT, random_word());
		send_item(MODE_POP_BACK, random_word());
		send_item(MODE_CLEAR, random_word());
		send_item(MODE_POP_FRONT, random_word());

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 52; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 52; end
				default: begin idle_pct = 9; stall_pct = 9; end
			endcase
			if (phase == 0)
				hold_req = 1'b1;
			left = PHASE_ITEMS;
			while (left > 0) begin
				kind = $urandom_range(9);
				burst = (kind == 9) ? 1 : $urandom_range(1, 20);
				for (int j = 0; j < burst && left > 0; j++) begin
					if (kind <= 3)
						send_item($urandom_range(1) ? MODE_PUSH_BACK : MODE_PUSH_FRONT,
							random_word());
					else if (kind <= 6)
						send_item($urandom_range(1) ? MODE_POP_BACK : MODE_POP_FRONT,
							random_word());
					else if (kind <= 8)
						send_item(MODE_W'($urandom_range(MODE_POP_BACK)), random_word());
					else
						send_item(MODE_W'($urandom_range(MODE_UNUSED_HI, MODE_CLEAR)),
							random_word());
					left--;
				end
			end
		end
		in_ch.valid <= 1'b0;

		while (tracker.pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		if (tracker.errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
